[src/omm_pkg.sv]
// ----------------------------------------------------------------------------
// omm_pkg
// types, coefficients and register codes shared by the octo motor mixer
// ----------------------------------------------------------------------------
package omm_pkg;

    localparam int PULSE_W = 12;
    localparam int DRIVE_W = 11;
    localparam int THR_W   = 16;
    localparam int COEF_W  = 16;
    localparam int SUM_W   = 16;
    localparam int NUM_MOTORS = 8;

    // frame geometry codes
    localparam logic [1:0] FRAME_X    = 2'd0;
    localparam logic [1:0] FRAME_PLUS = 2'd1;
    localparam logic [1:0] FRAME_V    = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRAME_MODE  = 3'd0;
    localparam logic [2:0] REG_PULSE_MIN   = 3'd1;
    localparam logic [2:0] REG_PULSE_MAX   = 3'd2;
    localparam logic [2:0] REG_IDLE_OFFSET = 3'd3;
    localparam logic [2:0] REG_CUT_ENABLE  = 3'd4;

    // reset values
    localparam logic [1:0]  RST_FRAME_MODE  = FRAME_X;
    localparam logic [11:0] RST_PULSE_MIN   = 12'd1100;
    localparam logic [11:0] RST_PULSE_MAX   = 12'd1900;
    localparam logic [8:0]  RST_IDLE_OFFSET = 9'd130;
    localparam logic        RST_CUT_ENABLE  = 1'b1;

    // unsigned q0.16 coefficients, rounded to nearest
    localparam logic [COEF_W-1:0] K_0P4  = 16'd26214;
    localparam logic [COEF_W-1:0] K_0P71 = 16'd46531;
    localparam logic [COEF_W-1:0] K_0P34 = 16'd22282;
    localparam logic [COEF_W-1:0] K_0P32 = 16'd20972;

    typedef struct packed {
        logic [1:0]  frame_mode;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [8:0]  idle_offset;
        logic        cut_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] yaw_drive;
        logic signed [DRIVE_W-1:0] pitch_drive;
        logic signed [DRIVE_W-1:0] roll_drive;
        logic [PULSE_W-1:0]        throttle_pulse;
        logic signed [THR_W-1:0]   throttle_command;
    } mix_in_t;

    typedef logic [NUM_MOTORS-1:0][PULSE_W-1:0] motor_vec_t;

    // drive * k / 65536, truncated toward zero
    function automatic logic signed [DRIVE_W:0] scale_q16(
        input logic signed [DRIVE_W-1:0] drive,
        input logic [COEF_W-1:0]         k
    );
        logic [DRIVE_W-1:0]        mag;
        logic [DRIVE_W+COEF_W-1:0] prod;
        logic [DRIVE_W:0]          p;
        mag  = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
        prod = (DRIVE_W+COEF_W)'(mag) * (DRIVE_W+COEF_W)'(k);
        p    = {1'b0, prod[DRIVE_W+COEF_W-1:COEF_W]};
        return drive[DRIVE_W-1] ? $signed(-p) : $signed(p);
    endfunction

endpackage

[src/omm_mix.sv]
// ----------------------------------------------------------------------------
// omm_mix
// combinational mix of one item into eight clamped motor pulse widths
// ----------------------------------------------------------------------------
module omm_mix (
    input  omm_pkg::cfg_t       cfg,
    input  omm_pkg::mix_in_t    item,
    output omm_pkg::motor_vec_t motors
);
    import omm_pkg::*;

    logic signed [SUM_W-1:0] base_s, r_s, p_s, y_s;
    logic signed [SUM_W-1:0] t1_s, t2_s, t3_s, t4_s;
    logic signed [SUM_W-1:0] r_half_s;
    logic signed [SUM_W-1:0] mix_s [NUM_MOTORS];
    logic signed [SUM_W-1:0] hi_s, lo_s, min_s;
    logic                    thr_pos;

    assign base_s = $signed({{(SUM_W-PULSE_W){1'b0}}, item.throttle_pulse});
    assign r_s    = {{(SUM_W-DRIVE_W){item.roll_drive[DRIVE_W-1]}}, item.roll_drive};
    assign p_s    = {{(SUM_W-DRIVE_W){item.pitch_drive[DRIVE_W-1]}}, item.pitch_drive};
    assign y_s    = {{(SUM_W-DRIVE_W){item.yaw_drive[DRIVE_W-1]}}, item.yaw_drive};

    // scaled terms; x frame uses t1/t2 at 0.4, plus at 0.71, v uses pitch at 0.34 / 0.32
    always_comb
    begin
        logic signed [DRIVE_W:0] a, b;
        case (cfg.frame_mode)
            FRAME_PLUS:
            begin
                a = scale_q16(item.roll_drive, K_0P71);
                b = scale_q16(item.pitch_drive, K_0P71);
            end
            FRAME_V:
            begin
                a = scale_q16(item.pitch_drive, K_0P34);
                b = scale_q16(item.pitch_drive, K_0P32);
            end
            default:
            begin
                a = scale_q16(item.roll_drive, K_0P4);
                b = scale_q16(item.pitch_drive, K_0P4);
            end
        endcase
        t1_s = {{(SUM_W-DRIVE_W-1){a[DRIVE_W]}}, a};
        t2_s = {{(SUM_W-DRIVE_W-1){b[DRIVE_W]}}, b};
        t3_s = t1_s;
        t4_s = t2_s;
    end

    // roll halved toward zero
    assign r_half_s = (r_s + $signed({{(SUM_W-1){1'b0}}, r_s[SUM_W-1]})) >>> 1;

    // order: ch1 ch2 ch3 ch4 ch7 ch8 ch10 ch11
    always_comb
    begin
        case (cfg.frame_mode)
            FRAME_PLUS:
            begin
                mix_s[0] = base_s + p_s;
                mix_s[1] = base_s - p_s;
                mix_s[2] = base_s - t1_s + t2_s;
                mix_s[3] = base_s - t1_s - t2_s;
                mix_s[4] = base_s + t1_s + t2_s;
                mix_s[5] = base_s + t1_s - t2_s;
                mix_s[6] = base_s + r_s;
                mix_s[7] = base_s - r_s;
            end
            FRAME_V:
            begin
                mix_s[0] = base_s + r_s + t3_s;
                mix_s[1] = base_s - r_s - t4_s;
                mix_s[2] = base_s + r_s - t4_s;
                mix_s[3] = base_s - p_s - r_half_s;
                mix_s[4] = base_s + p_s + r_s;
                mix_s[5] = base_s - r_s + t3_s;
                mix_s[6] = base_s + p_s - r_s;
                mix_s[7] = base_s - p_s + r_half_s;
            end
            default:
            begin
                mix_s[0] = base_s + p_s - t1_s;
                mix_s[1] = base_s - p_s + t1_s;
                mix_s[2] = base_s - r_s + t2_s;
                mix_s[3] = base_s - p_s - t1_s;
                mix_s[4] = base_s + p_s + t1_s;
                mix_s[5] = base_s + r_s - t2_s;
                mix_s[6] = base_s + r_s + t2_s;
                mix_s[7] = base_s - r_s - t2_s;
            end
        endcase
    end

    assign thr_pos = !item.throttle_command[THR_W-1] && (item.throttle_command != '0);
    assign hi_s    = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.pulse_max});
    assign min_s   = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.pulse_min});
    assign lo_s    = min_s + (thr_pos ? $signed({{(SUM_W-9){1'b0}}, cfg.idle_offset})
                                      : $signed(SUM_W'(0)));

    always_comb
    begin
        logic signed [SUM_W-1:0] v;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            // yaw: counter-clockwise on ch3 ch4 ch7 ch8
            v = (i >= 2 && i <= 5) ? mix_s[i] + y_s : mix_s[i] - y_s;
            if (v > hi_s)
                v = hi_s;
            if (v < lo_s)
                v = lo_s;
            if (cfg.cut_enable && !thr_pos)
                v = min_s;
            if (v > $signed(SUM_W'(4095)))
                motors[i] = '1;
            else if (v < $signed(SUM_W'(0)))
                motors[i] = '0;
            else
                motors[i] = v[PULSE_W-1:0];
        end
    end

endmodule

[src/octo_motor_mixer_top.sv]
// ----------------------------------------------------------------------------
// octo_motor_mixer_top
// octocopter motor mixer for x, plus and v frames with apb configuration
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_*       | in        | throttle_command, throttle_pulse, roll, pitch, yaw
//  m_*       | out       | eight motor pulse widths
//  apb       | in/out    | frame_mode, pulse_min, pulse_max, idle_offset,
//            |           | cut_enable at 0x00..0x10
//
//  an item passes from input to output through an input register, the
//  mix and clamp logic, then the result register. one item per cycle
//  unless m_tready stalls. rst_n clears both valid bits and loads the
//  register reset values. a stall on m_tready holds the result; the input
//  register still takes one more item, then s_tready drops.
// ----------------------------------------------------------------------------
module octo_motor_mixer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // throttle_command[15:0], throttle_pulse[27:16], roll_drive[38:28],
    // pitch_drive[49:39], yaw_drive[60:50], zero pad [63:61]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // motor_ch1[11:0], ch2[23:12], ch3[35:24], ch4[47:36], ch7[59:48],
    // ch8[71:60], ch10[83:72], ch11[95:84]
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import omm_pkg::*;

    cfg_t       cfg_reg;
    mix_in_t    in_data_reg;
    logic       in_vld_reg;
    logic       out_vld_reg;
    motor_vec_t out_data_reg;
    motor_vec_t motors;
    logic       out_adv;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_mode  <= RST_FRAME_MODE;
            cfg_reg.pulse_min   <= RST_PULSE_MIN;
            cfg_reg.pulse_max   <= RST_PULSE_MAX;
            cfg_reg.idle_offset <= RST_IDLE_OFFSET;
            cfg_reg.cut_enable  <= RST_CUT_ENABLE;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_FRAME_MODE:  cfg_reg.frame_mode  <= pwdata[1:0];
                REG_PULSE_MIN:   cfg_reg.pulse_min   <= pwdata[11:0];
                REG_PULSE_MAX:   cfg_reg.pulse_max   <= pwdata[11:0];
                REG_IDLE_OFFSET: cfg_reg.idle_offset <= pwdata[8:0];
                REG_CUT_ENABLE:  cfg_reg.cut_enable  <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_MODE:  prdata = {30'd0, cfg_reg.frame_mode};
            REG_PULSE_MIN:   prdata = {20'd0, cfg_reg.pulse_min};
            REG_PULSE_MAX:   prdata = {20'd0, cfg_reg.pulse_max};
            REG_IDLE_OFFSET: prdata = {23'd0, cfg_reg.idle_offset};
            REG_CUT_ENABLE:  prdata = {31'd0, cfg_reg.cut_enable};
            default:         prdata = '0;
        endcase
    end

    // datapath handshake
    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (out_adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= mix_in_t'(s_tdata[60:0]);
        if (out_adv && in_vld_reg)
            out_data_reg <= motors;
    end

    omm_mix u_mix (
        .cfg    (cfg_reg),
        .item   (in_data_reg),
        .motors (motors)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

[src/omm_checker.sv]
// ----------------------------------------------------------------------------
// omm_checker
// port-level checks on the octo motor mixer stream channels
// ----------------------------------------------------------------------------
module omm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // with the output empty the pipeline can always take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // an accepted item reaches the output through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted item did not reach output");

endmodule

bind octo_motor_mixer_top omm_checker u_omm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
